FILE: sv/nvse_pkg.sv
// Shared types, constants and helpers for the VTG speed extractor.
// No dependencies; used by every module of the block.
package nvse_pkg;

  // Input beat: one received character or one timer tick
  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } nvse_in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] speed;
    logic       speed_pending;
  } nvse_out_t;

  // Freshly parsed speed, parser to timer
  typedef struct packed {
    logic       valid;
    logic [7:0] speed;
  } nvse_speed_upd_t;

  // Next published state, timer to result register
  typedef struct packed {
    logic [7:0] speed;
    logic       pending;
  } nvse_status_t;

  // Parser phases, one-hot
  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_COMMAS = 4'b0100,
    PH_DIGITS = 4'b1000
  } nvse_phase_e;

  // Input beat kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Configuration register indexes
  localparam logic REG_TIMEOUT_TICKS      = 1'b0;
  localparam logic REG_SPEED_FIELD_COMMAS = 1'b1;

  localparam logic [15:0] TIMEOUT_TICKS_RST      = 16'd3000;
  localparam logic [7:0]  SPEED_FIELD_COMMAS_RST = 8'd7;

  localparam logic [7:0]  CHAR_DOLLAR = 8'h24;
  localparam logic [7:0]  CHAR_COMMA  = 8'h2C;
  localparam logic [7:0]  CHAR_DOT    = 8'h2E;
  localparam logic [7:0]  CHAR_ZERO   = 8'h30;

  localparam logic [2:0]  HEADER_LEN  = 3'd5;
  localparam logic [7:0]  MAX_DIGITS  = 8'd3;
  localparam logic [7:0]  NO_SIGNAL   = 8'hFF;
  localparam logic [16:0] TIMEOUT_EXTRA = 17'd10;

  // Expected header characters "GPVTG"
  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h56;
      3'd3:    c = 8'h54;
      3'd4:    c = 8'h47;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/nvse_parser.sv
// Sentence parser: header check, comma count and speed digit capture.
// Depends on nvse_pkg.
module nvse_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [7:0]               rx_byte_i,
  input  logic [7:0]               speed_field_commas_i,
  output nvse_pkg::nvse_speed_upd_t upd_o
);
  import nvse_pkg::*;

  nvse_phase_e phase_q, phase_d;
  logic [7:0]  pos_q, pos_d;
  logic        mismatch_q, mismatch_d;
  logic [7:0]  digit_q [3];
  logic        digit_we;
  logic [7:0]  comma_cnt;
  logic [7:0]  hdr_next;
  logic        hdr_bad;
  logic [7:0]  val1, val2, val3;
  logic        is_comma;

  assign is_comma  = (rx_byte_i == CHAR_COMMA);
  assign comma_cnt = pos_q + {7'd0, is_comma};
  assign hdr_next  = pos_q + 8'd1;
  assign hdr_bad   = (rx_byte_i != header_char(pos_q[2:0]));

  // Decimal value of the captured digits, modulo 256
  assign val1 = digit_q[0];
  assign val2 = 8'(digit_q[0] * 8'd10) + digit_q[1];
  assign val3 = 8'(digit_q[0] * 8'd100) + 8'(digit_q[1] * 8'd10) + digit_q[2];

  // Next parser state for one received character
  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    mismatch_d   = mismatch_q;
    digit_we     = 1'b0;
    upd_o.valid  = 1'b0;
    upd_o.speed  = val1;
    case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == CHAR_DOLLAR) begin
          phase_d    = PH_HEADER;
          pos_d      = 8'd0;
          mismatch_d = 1'b0;
        end
      end
      PH_HEADER: begin
        // note a mismatch, act on it after the fifth header byte
        mismatch_d = mismatch_q | hdr_bad;
        pos_d      = hdr_next;
        if (hdr_next >= {5'd0, HEADER_LEN}) begin
          phase_d    = (mismatch_q | hdr_bad) ? PH_HUNT : PH_COMMAS;
          pos_d      = 8'd0;
          mismatch_d = 1'b0;
        end
      end
      PH_COMMAS: begin
        pos_d = comma_cnt;
        if (comma_cnt == speed_field_commas_i) begin
          pos_d   = 8'd0;
          phase_d = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (is_comma || rx_byte_i == CHAR_DOT) begin
          // close the field; an empty or overlong field gives nothing
          upd_o.valid = (pos_q >= 8'd1) && (pos_q <= MAX_DIGITS);
          case (pos_q[1:0])
            2'd1:    upd_o.speed = val1;
            2'd2:    upd_o.speed = val2;
            default: upd_o.speed = val3;
          endcase
          pos_d   = 8'd0;
          phase_d = PH_HUNT;
        end else begin
          digit_we = (pos_q < MAX_DIGITS);
          if (pos_q <= MAX_DIGITS) begin
            pos_d = pos_q + 8'd1;
          end
        end
      end
      default: begin
        phase_d = PH_HUNT;
        pos_d   = 8'd0;
      end
    endcase
    upd_o.valid = upd_o.valid & en_i;
  end

  // Parser control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      pos_q      <= 8'd0;
      mismatch_q <= 1'b0;
    end else if (en_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      mismatch_q <= mismatch_d;
    end
  end

  // Digit store, only entries of the current field are read
  always_ff @(posedge clk_i) begin
    if (en_i && digit_we) begin
      digit_q[pos_q[1:0]] <= rx_byte_i - CHAR_ZERO;
    end
  end

endmodule

FILE: sv/nvse_timer.sv
// Pending speed, publish on tick and no-signal timeout.
// Depends on nvse_pkg.
module nvse_timer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      tick_i,
  input  nvse_pkg::nvse_speed_upd_t upd_i,
  input  logic [15:0]               timeout_ticks_i,
  output nvse_pkg::nvse_status_t    status_o
);
  import nvse_pkg::*;

  logic [7:0]  pend_speed_q, pend_speed_d;
  logic        pend_q, pend_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  pub_q, pub_d;
  logic [15:0] cnt_inc;
  logic [16:0] limit_sum;
  logic [15:0] limit_sat;

  assign cnt_inc   = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
  assign limit_sum = {1'b0, timeout_ticks_i} + TIMEOUT_EXTRA;
  assign limit_sat = limit_sum[16] ? 16'hFFFF : limit_sum[15:0];

  // Next timer state for one beat
  always_comb begin
    pend_speed_d = pend_speed_q;
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    pub_d        = pub_q;
    if (tick_i) begin
      if (pend_q) begin
        pend_d = 1'b0;
        cnt_d  = 16'd0;
        pub_d  = pend_speed_q;
      end else begin
        cnt_d = cnt_inc;
        if (cnt_inc > timeout_ticks_i) begin
          cnt_d = limit_sat;
          pub_d = NO_SIGNAL;
        end
      end
    end else if (upd_i.valid) begin
      // a new field overwrites a pending one
      pend_speed_d = upd_i.speed;
      pend_d       = 1'b1;
    end
  end

  assign status_o.speed   = pub_d;
  assign status_o.pending = pend_d;

  // Advance on each beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_speed_q <= 8'd0;
      pend_q       <= 1'b0;
      cnt_q        <= 16'd0;
      pub_q        <= 8'd0;
    end else if (en_i) begin
      pend_speed_q <= pend_speed_d;
      pend_q       <= pend_d;
      cnt_q        <= cnt_d;
      pub_q        <= pub_d;
    end
  end

endmodule

FILE: sv/nmea_vtg_speed_extractor_core.sv
// VTG speed extractor top level: input register, parser, timer, result register.
// Depends on nvse_pkg, nvse_parser and nvse_timer.
//
// Takes one beat per cycle unless a full result register is stalled, each a
// received NMEA character or a timer tick, and returns exactly one result beat
// per input beat: the published speed (255 means no signal) and whether a
// parsed speed awaits the next tick. A beat passes the input register, then
// the state update and the result register. Write configuration only while
// idle.
module nmea_vtg_speed_extractor_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nvse_pkg::nvse_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nvse_pkg::nvse_out_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import nvse_pkg::*;

  logic            in_valid_q;
  nvse_in_t        in_data_q;
  logic            out_valid_q;
  nvse_out_t       out_data_q;
  logic            advance;
  logic [15:0]     timeout_ticks_q;
  logic [7:0]      speed_field_commas_q;
  nvse_speed_upd_t upd;
  nvse_status_t    status;

  // Move a beat from input register to result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q      <= TIMEOUT_TICKS_RST;
      speed_field_commas_q <= SPEED_FIELD_COMMAS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TIMEOUT_TICKS:      timeout_ticks_q      <= cfg_wdata_i;
        REG_SPEED_FIELD_COMMAS: speed_field_commas_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  nvse_parser u_parser (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .en_i                 (advance && (in_data_q.mode == MODE_BYTE)),
    .rx_byte_i            (in_data_q.rx_byte),
    .speed_field_commas_i (speed_field_commas_q),
    .upd_o                (upd)
  );

  nvse_timer u_timer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .tick_i          (in_data_q.mode == MODE_TICK),
    .upd_i           (upd),
    .timeout_ticks_i (timeout_ticks_q),
    .status_o        (status)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q.speed         <= status.speed;
      out_data_q.speed_pending <= status.pending;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/nvse_checker.sv
// Port-level checks for the VTG speed extractor, bound to the top level.
// Depends on nvse_pkg and nmea_vtg_speed_extractor_core.
module nvse_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input nvse_pkg::nvse_out_t out_data_o
);
  import nvse_pkg::*;

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // With the result register empty, the input side never stalls
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // A draining consumer keeps the input side open
  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while results drain");

endmodule

bind nmea_vtg_speed_extractor_core nvse_checker u_nvse_checker (.*);

FILE: tb/nmea_vtg_speed_extractor_core_tb.sv
// Self-checking testbench for the VTG speed extractor core.
// Depends on nvse_pkg and nmea_vtg_speed_extractor_core; drives directed and random
// NMEA traffic and ticks and checks every result beat against a predictor.
`timescale 1ns / 1ps

module nmea_vtg_speed_extractor_core_tb;
  import nvse_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 60;
  localparam logic [39:0] VTG_TAG = "GPVTG";

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  nvse_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  nvse_out_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_TIMEOUT_TICKS;
  logic [15:0] cfg_wdata_i = '0;

  // Pending beats for the driver and expected result beats for the checker
  nvse_in_t  beat_q[$];
  nvse_out_t speed_exp_q[$];

  int items_queued = 0;
  int fail_count = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;
  int stuck_cycles = 0;

  // Predictor state and its copy of the registers
  nvse_phase_e phase_m;
  logic [7:0]  pos_m;
  logic        hdr_bad_m;
  logic [7:0]  digits_m [3];
  logic [7:0]  pend_speed_m;
  logic        pend_m;
  logic [15:0] ticks_m;
  logic [7:0]  pub_m;
  logic [15:0] cfg_timeout_m;
  logic [7:0]  cfg_commas_m;

  nmea_vtg_speed_extractor_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [7:0] tag_char(input int idx);
    return VTG_TAG[8 * (4 - idx) +: 8];
  endfunction

  function automatic void clear_speed_state();
    phase_m       = PH_HUNT;
    pos_m         = '0;
    hdr_bad_m     = 1'b0;
    digits_m      = '{default: '0};
    pend_speed_m  = '0;
    pend_m        = 1'b0;
    ticks_m       = '0;
    pub_m         = '0;
    cfg_timeout_m = TIMEOUT_TICKS_RST;
    cfg_commas_m  = SPEED_FIELD_COMMAS_RST;
  endfunction

  // Advance the predictor by one beat and return the result it should give
  function automatic nvse_out_t predict_speed(input nvse_in_t beat);
    nvse_out_t   res;
    int unsigned v;
    logic [16:0] t;
    logic [7:0]  c;
    c = beat.rx_byte;
    if (beat.mode == MODE_TICK) begin
      if (pend_m) begin
        pend_m  = 1'b0;
        ticks_m = '0;
        pub_m   = pend_speed_m;
      end else begin
        if (ticks_m != 16'hFFFF) ticks_m++;
        if (ticks_m > cfg_timeout_m) begin
          t = {1'b0, cfg_timeout_m} + TIMEOUT_EXTRA;
          ticks_m = t[16] ? 16'hFFFF : t[15:0];
          pub_m = NO_SIGNAL;
        end
      end
    end else begin
      case (phase_m)
        PH_HUNT: begin
          if (c == CHAR_DOLLAR) begin
            phase_m   = PH_HEADER;
            pos_m     = '0;
            hdr_bad_m = 1'b0;
          end
        end
        PH_HEADER: begin
          // any byte, a dollar too, fills the next header slot
          if (pos_m < 5 && c != tag_char(pos_m)) hdr_bad_m = 1'b1;
          pos_m++;
          if (pos_m >= 5) begin
            phase_m   = hdr_bad_m ? PH_HUNT : PH_COMMAS;
            pos_m     = '0;
            hdr_bad_m = 1'b0;
          end
        end
        PH_COMMAS: begin
          if (c == CHAR_COMMA) pos_m = pos_m + 8'd1;
          if (pos_m == cfg_commas_m) begin
            pos_m   = '0;
            phase_m = PH_DIGITS;
          end
        end
        default: begin
          if (c == CHAR_COMMA || c == CHAR_DOT) begin
            if (pos_m >= 1 && pos_m <= MAX_DIGITS) begin
              v = 0;
              for (int i = 0; i < pos_m; i++) v = v * 10 + digits_m[i];
              pend_speed_m = v[7:0];
              pend_m       = 1'b1;
            end
            pos_m   = '0;
            phase_m = PH_HUNT;
          end else begin
            if (pos_m < MAX_DIGITS) digits_m[pos_m] = c - CHAR_ZERO;
            if (pos_m <= MAX_DIGITS) pos_m++;
          end
        end
      endcase
    end
    res.speed         = pub_m;
    res.speed_pending = pend_m;
    return res;
  endfunction

  // Mostly no gap, some short ones, a few long ones, and calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: count accepted beats into the predictor, then present the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) speed_exp_q.push_back(predict_speed(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (beat_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= beat_q.pop_front();
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    nvse_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (speed_exp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= PRINT_CAP)
            $display("%0t: unexpected result beat, expected none, got speed %0d pending %0b",
                     $time, out_data_o.speed, out_data_o.speed_pending);
        end else begin
          want = speed_exp_q.pop_front();
          if (out_data_o.speed !== want.speed) begin
            fail_count++;
            if (fail_count <= PRINT_CAP)
              $display("%0t: speed mismatch, expected %0d, got %0d",
                       $time, want.speed, out_data_o.speed);
          end
          if (out_data_o.speed_pending !== want.speed_pending) begin
            fail_count++;
            if (fail_count <= PRINT_CAP)
              $display("%0t: speed_pending mismatch, expected %0b, got %0b",
                       $time, want.speed_pending, out_data_o.speed_pending);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall = pick_gap(recv_calm);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, stuck_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] c);
    nvse_in_t b;
    b.mode    = MODE_BYTE;
    b.rx_byte = c;
    beat_q.push_back(b);
    items_queued++;
  endtask

  task automatic queue_tick();
    nvse_in_t b;
    b.mode    = MODE_TICK;
    b.rx_byte = 8'($urandom);
    beat_q.push_back(b);
    items_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 85) return CHAR_ZERO + 8'($urandom_range(0, 9));
    do c = 8'($urandom); while (c == CHAR_COMMA || c == CHAR_DOT);
    return c;
  endfunction

  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CHAR_COMMA);
    return c;
  endfunction

  function automatic int field_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return 4;
    return $urandom_range(5, 7);
  endfunction

  // Header, commas with optional filler, a speed field and its terminator
  task automatic queue_sentence(input int n_commas, input int n_chars, input bit dot_end);
    queue_byte(CHAR_DOLLAR);
    for (int i = 0; i < 5; i++) queue_byte(tag_char(i));
    for (int i = 0; i < n_commas; i++) begin
      if ($urandom_range(0, 3) == 0) queue_byte(filler_char());
      queue_byte(CHAR_COMMA);
    end
    for (int i = 0; i < n_chars; i++) queue_byte(field_char());
    queue_byte(dot_end ? CHAR_DOT : CHAR_COMMA);
  endtask

  // Mostly well-formed sentences, the rest broken headers, cut sentences and noise
  task automatic queue_traffic(input int n_items);
    int start;
    int r;
    int bad;
    logic [7:0] c;
    start = items_queued;
    while (items_queued - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        queue_sentence(cfg_commas_m, field_len(), $urandom_range(0, 1));
      end else if (r < 75) begin
        queue_byte(CHAR_DOLLAR);
        bad = $urandom_range(0, 4);
        for (int i = 0; i < 5; i++) begin
          do c = 8'($urandom); while (c == tag_char(i));
          queue_byte(i == bad ? c : tag_char(i));
        end
        queue_text(",12,");
      end else if (r < 85) begin
        queue_byte(CHAR_DOLLAR);
        for (int i = 0; i < 5; i++) queue_byte(tag_char(i));
        repeat ($urandom_range(0, cfg_commas_m)) queue_byte(CHAR_COMMA);
      end else begin
        repeat ($urandom_range(1, 8)) queue_byte(8'($urandom));
      end
      repeat ($urandom_range(0, 3)) queue_tick();
    end
  endtask

  // Hold until every beat has gone in and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (beat_q.size() != 0 || in_valid_i || speed_exp_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] timeout, input logic [7:0] commas);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TIMEOUT_TICKS;
    cfg_wdata_i <= timeout;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SPEED_FIELD_COMMAS;
    cfg_wdata_i <= {8'd0, commas};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_timeout_m = timeout;
    cfg_commas_m  = commas;
  endtask

  initial begin
    clear_speed_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: short field position, fast timeout
    set_config(16'd2, 8'd1);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_text("$GPVTG,7,");
    queue_tick();
    // three digits wrap to 8 bits, then a new field overwrites the pending one
    queue_text("$GPVTG,999.");
    queue_text("$GPVTG,12,");
    queue_tick();
    // long field and empty field give no speed
    queue_text("$GPVTG,1234,");
    queue_text("$GPVTG,,");
    queue_tick();
    // a second dollar is taken as a header byte and spoils the header
    queue_text("$$GPVTG,5,");
    // non-digit characters used as digit values
    queue_text("$GPVTG,A:,");
    queue_tick();
    queue_text("$GPVTG,");
    queue_byte(8'hFF);
    queue_text("0.");
    // publish, then run into the timeout
    repeat (5) queue_tick();
    wait_drained();

    // Reset values, then random traffic
    set_config(TIMEOUT_TICKS_RST, SPEED_FIELD_COMMAS_RST);
    queue_traffic(70);
    wait_drained();

    // Low settings: timeouts come often
    set_config(16'd1, 8'd1);
    queue_traffic(100);
    wait_drained();

    // Random middle settings, with a full drain between the halves
    set_config(16'($urandom_range(2, 60)), 8'($urandom_range(2, 12)));
    queue_traffic(70);
    wait_drained();
    queue_traffic(70);
    wait_drained();

    // Zero commas: first byte after the header is dropped, comma count wraps
    set_config(16'd5, 8'd0);
    queue_text("$GPVTGX42,");
    queue_tick();
    queue_text("$GPVTG");
    repeat (256) queue_byte(CHAR_COMMA);
    queue_text("17,");
    queue_tick();
    wait_drained();

    // High settings last: the speed field stays out of reach, ticks stay under the limit
    set_config(16'd65000, 8'd255);
    queue_text("$GPVTG");
    repeat (20) queue_byte(CHAR_COMMA);
    repeat (30) queue_tick();
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/nvse_pkg.sv
sv/nvse_parser.sv
sv/nvse_timer.sv
sv/nmea_vtg_speed_extractor_core.sv
sv/nvse_checker.sv
tb/nmea_vtg_speed_extractor_core_tb.sv
